@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the tone curve rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tone curve assertion failed");

// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `ASSERT_CLK(lbl, clk, rst_n, !(cond))

`endif

@@ rtl/core/gtc_pkg.sv @@
// shared constants, types and constant functions of the gray tone curve
package gtc_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int MANT_BITS     = 30;
  localparam int LOG_BITS      = 20;
  localparam logic [15:0] GAIN_ONE = 16'd4096;

  typedef enum logic [2:0] {
    REG_BLACK     = 3'd0,
    REG_WHITE     = 3'd1,
    REG_INV_GAMMA = 3'd2,
    REG_GAIN      = 3'd3,
    REG_OFFSET    = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] black;
    logic [15:0] white;
    logic [15:0] inv_gamma;
    logic [15:0] gain;
    logic [16:0] offset;
  } cfg_t;

  // width of an internal gray value: full scale or any raw 16 bit input
  function automatic int val_width(int frac);
    return (frac + 8 > 16) ? frac + 8 : 16;
  endfunction

  function automatic logic [63:0] isqrt(logic [63:0] a);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bv;
    rem = a;
    res = '0;
    bv  = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bv) begin
        rem = rem - (res + bv);
        res = (res >> 1) + bv;
      end else begin
        res = res >> 1;
      end
      bv = bv >> 2;
    end
    return res;
  endfunction

  // 2^(-2^-k) in q30, built by repeated square roots
  function automatic logic [MANT_BITS:0] exp_root(int k);
    logic [63:0] r;
    r = isqrt(64'd1 << 59);
    for (int i = 1; i < k; i++) begin
      r = isqrt(r << MANT_BITS);
    end
    return r[MANT_BITS:0];
  endfunction

endpackage

@@ rtl/core/gtc_div.sv @@
// pipelined restoring divider, one quotient bit per stage
module gtc_div #(
  parameter int QB = 16,
  parameter int DW = 16,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [DW-1:0] rem_i,
  input  logic [QB-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QB-1:0] quot_o,
  output logic [SW-1:0] side_o
);

  logic [QB-1:0] valid_q;
  logic [DW-1:0] rem_q  [QB];
  logic [QB-1:0] nq_q   [QB];
  logic [SW-1:0] side_q [QB];

  for (genvar s = 0; s < QB; s++) begin : g_stage
    logic          cv;
    logic [DW-1:0] cr;
    logic [QB-1:0] cn;
    logic [SW-1:0] cs;
    logic [DW:0]   r2;
    logic          ge;

    if (s == 0) begin : g_first
      assign cv = valid_i;
      assign cr = rem_i;
      assign cn = num_i;
      assign cs = side_i;
    end else begin : g_next
      assign cv = valid_q[s-1];
      assign cr = rem_q[s-1];
      assign cn = nq_q[s-1];
      assign cs = side_q[s-1];
    end

    // numerator bits shift out at the top, quotient bits shift in below
    assign r2 = {cr, cn[QB-1]};
    assign ge = (r2 >= {1'b0, den_i});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else begin
        valid_q[s] <= cv;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= ge ? DW'(r2 - {1'b0, den_i}) : r2[DW-1:0];
      nq_q[s]   <= {cn[QB-2:0], ge};
      side_q[s] <= cs;
    end
  end

  assign valid_o = valid_q[QB-1];
  assign quot_o  = nq_q[QB-1];
  assign side_o  = side_q[QB-1];

endmodule

@@ rtl/core/gtc_levels.sv @@
// levels stage: stretch black..white to full scale, or pass the raw value when white <= black
`include "assert_macros.svh"

module gtc_levels #(
  parameter int FRAC_BITS = gtc_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  gtc_pkg::cfg_t                           cfg_i,
  input  logic                                    valid_i,
  input  logic [15:0]                             gray_i,
  output logic                                    valid_o,
  output logic [gtc_pkg::val_width(FRAC_BITS)-1:0] val_o
);

  localparam int VW = gtc_pkg::val_width(FRAC_BITS);
  localparam int QB = FRAC_BITS + 8;
  localparam logic [VW-1:0] FULL = VW'(255 << FRAC_BITS);

  typedef struct packed {
    logic          fixed;
    logic [VW-1:0] val;
  } side_t;

  logic [15:0] diff;
  logic [23:0] scaled;
  side_t       side_d;

  logic          a_valid_q;
  side_t         a_side_q;
  logic [15:0]   a_rem_q;
  logic [QB-1:0] a_num_q;
  logic [15:0]   den_q;

  logic          dv;
  logic [QB-1:0] dq;
  side_t         ds;

  logic          valid_q;
  logic [VW-1:0] val_q;

  // (v - black) * 255, the 2^frac factor only adds zero bits below
  assign diff   = gray_i - cfg_i.black;
  assign scaled = {diff, 8'b0} - {8'b0, diff};

  always_comb begin
    side_d.fixed = 1'b1;
    side_d.val   = '0;
    if (cfg_i.white <= cfg_i.black) begin
      side_d.val = VW'(gray_i);
    end else if (gray_i <= cfg_i.black) begin
      side_d.val = '0;
    end else if (gray_i >= cfg_i.white) begin
      side_d.val = FULL;
    end else begin
      side_d.fixed = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      a_valid_q <= valid_i;
      valid_q   <= dv;
    end
  end

  always_ff @(posedge clk_i) begin
    a_side_q <= side_d;
    a_rem_q  <= scaled[23:8];
    a_num_q  <= {scaled[7:0], {FRAC_BITS{1'b0}}};
    den_q    <= cfg_i.white - cfg_i.black;
    val_q    <= ds.fixed ? ds.val : VW'(dq);
  end

  gtc_div #(
    .QB(QB),
    .DW(16),
    .SW($bits(side_t))
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (a_valid_q),
    .rem_i   (a_rem_q),
    .num_i   (a_num_q),
    .den_i   (den_q),
    .side_i  (a_side_q),
    .valid_o (dv),
    .quot_o  (dq),
    .side_o  (ds)
  );

  assign valid_o = valid_q;
  assign val_o   = val_q;

  `ASSERT_CLK(a_lvl_range, clk_i, rst_ni, valid_q && (cfg_i.white > cfg_i.black) |-> val_q <= FULL)

endmodule

@@ rtl/core/gtc_gamma.sv @@
// gamma stage: log2, scale by reciprocal gamma, exp2
`include "assert_macros.svh"

module gtc_gamma #(
  parameter int FRAC_BITS = gtc_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  gtc_pkg::cfg_t                           cfg_i,
  input  logic                                    valid_i,
  input  logic [gtc_pkg::val_width(FRAC_BITS)-1:0] val_i,
  output logic                                    valid_o,
  output logic [gtc_pkg::val_width(FRAC_BITS)-1:0] val_o
);

  localparam int VW = gtc_pkg::val_width(FRAC_BITS);
  localparam int DW = FRAC_BITS + 8;
  localparam int MB = gtc_pkg::MANT_BITS;
  localparam int MW = MB + 1;
  localparam int LB = gtc_pkg::LOG_BITS;
  localparam int EW = 5;
  localparam int LW = EW + LB;
  localparam int PW = LW + 16;
  localparam int NS = 5;
  localparam logic [VW-1:0] FULL = VW'(255 << FRAC_BITS);

  typedef struct packed {
    logic          fixed;
    logic [VW-1:0] val;
  } side_t;

  // entry: special cases
  side_t         s0_d;
  logic          in_valid_q;
  side_t         in_side_q;
  logic [DW-1:0] in_rem_q;

  always_comb begin
    s0_d.fixed = 1'b1;
    s0_d.val   = '0;
    if (cfg_i.inv_gamma == gtc_pkg::GAIN_ONE) begin
      s0_d.val = val_i;
    end else if (cfg_i.inv_gamma == '0) begin
      s0_d.val = FULL;
    end else if (val_i == '0) begin
      s0_d.val = '0;
    end else if (val_i >= FULL) begin
      s0_d.val = FULL;
    end else begin
      s0_d.fixed = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    in_side_q <= s0_d;
    in_rem_q  <= val_i[DW-1:0];
  end

  // t = x * 2^30 / full, that is x / 255 scaled by 2^(30 - FRAC_BITS): the
  // quotient comes from a reciprocal estimate with one correction, and the
  // fraction of a remainder below 255 repeats its own byte in binary
  localparam int KB = MB - FRAC_BITS;
  localparam int AW = FRAC_BITS + 1;

  logic [DW:0]   rsum;
  logic          rv_q;
  side_t         rs_q;
  logic [DW-1:0] rx_q;
  logic [AW-1:0] ra_q;
  logic [DW-1:0] rb;
  logic [AW-1:0] qa;
  logic [7:0]    qb;
  logic [31:0]   qrep;
  logic          tv_q;
  logic [MB-1:0] tq_q;
  side_t         ts_q;
  side_t         dside;

  assign rsum = {1'b0, in_rem_q} + (DW+1)'(in_rem_q >> 8) + (DW+1)'(in_rem_q >> 16);
  assign rb   = rx_q - DW'({ra_q, 8'b0} - {8'b0, ra_q});
  assign qrep = {4{qb}};

  // the estimate is low by at most one
  always_comb begin
    if (rb >= DW'(255)) begin
      qa = ra_q + AW'(1);
      qb = 8'(rb - DW'(255));
    end else begin
      qa = ra_q;
      qb = rb[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
      tv_q <= 1'b0;
    end else begin
      rv_q <= in_valid_q;
      tv_q <= rv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rs_q <= in_side_q;
    rx_q <= in_rem_q;
    ra_q <= rsum[DW:8];
    ts_q <= rs_q;
    tq_q <= {qa[FRAC_BITS-1:0], qrep[31 -: KB]};
  end

  always_comb begin
    dside = ts_q;
    if (!ts_q.fixed && tq_q == '0) begin
      dside.fixed = 1'b1;
      dside.val   = '0;
    end
  end

  // normalise into [1,2) with a binary shift search
  logic [NS-1:0] nv_q;
  logic [MW-1:0] nm_q [NS];
  logic [EW-1:0] ne_q [NS];
  side_t         ns_q [NS];

  for (genvar s = 0; s < NS; s++) begin : g_norm
    localparam int SH = 16 >> s;
    logic          cv;
    logic [MW-1:0] cm;
    logic [EW-1:0] ce;
    side_t         cs;

    if (s == 0) begin : g_first
      assign cv = tv_q;
      assign cm = {1'b0, tq_q};
      assign ce = '0;
      assign cs = dside;
    end else begin : g_next
      assign cv = nv_q[s-1];
      assign cm = nm_q[s-1];
      assign ce = ne_q[s-1];
      assign cs = ns_q[s-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        nv_q[s] <= 1'b0;
      end else begin
        nv_q[s] <= cv;
      end
    end

    always_ff @(posedge clk_i) begin
      ns_q[s] <= cs;
      if (cm[MW-1 -: SH] == '0) begin
        nm_q[s] <= cm << SH;
        ne_q[s] <= ce + EW'(SH);
      end else begin
        nm_q[s] <= cm;
        ne_q[s] <= ce;
      end
    end
  end

  // log2 fraction bits by square and compare
  logic [LB-1:0] lv_q;
  logic [MW-1:0] lm_q [LB];
  logic [LB-1:0] lf_q [LB];
  logic [EW-1:0] le_q [LB];
  side_t         ls_q [LB];

  for (genvar s = 0; s < LB; s++) begin : g_log
    logic          cv;
    logic [MW-1:0] cm;
    logic [LB-1:0] cf;
    logic [EW-1:0] ce;
    side_t         cs;
    logic [2*MW-1:0] sq;
    logic [MW:0]   hi;

    if (s == 0) begin : g_first
      assign cv = nv_q[NS-1];
      assign cm = nm_q[NS-1];
      assign cf = '0;
      assign ce = ne_q[NS-1];
      assign cs = ns_q[NS-1];
    end else begin : g_next
      assign cv = lv_q[s-1];
      assign cm = lm_q[s-1];
      assign cf = lf_q[s-1];
      assign ce = le_q[s-1];
      assign cs = ls_q[s-1];
    end

    assign sq = cm * cm;
    assign hi = sq[2*MW-1:MB];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        lv_q[s] <= 1'b0;
      end else begin
        lv_q[s] <= cv;
      end
    end

    always_ff @(posedge clk_i) begin
      lm_q[s] <= hi[MW] ? hi[MW:1] : hi[MW-1:0];
      lf_q[s] <= {cf[LB-2:0], hi[MW]};
      le_q[s] <= ce;
      ls_q[s] <= cs;
    end
  end

  // log2 of the input as a positive q20 magnitude, then times 1/gamma
  logic          gv_q;
  logic [LW-1:0] lg_q;
  side_t         gs_q;
  logic [PW-1:0] gprod;
  logic [PW-13:0] mg;
  side_t         ms_d;
  logic          mv_q;
  logic [LB-1:0] mf_q;
  logic [EW-1:0] mn_q;
  side_t         ms_q;

  assign gprod = lg_q * cfg_i.inv_gamma;
  assign mg    = gprod[PW-1:12];

  always_comb begin
    ms_d = gs_q;
    if (!gs_q.fixed && mg[PW-13:LB] >= (PW-12-LB)'(MW)) begin
      ms_d.fixed = 1'b1;
      ms_d.val   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gv_q <= 1'b0;
      mv_q <= 1'b0;
    end else begin
      gv_q <= lv_q[LB-1];
      mv_q <= gv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lg_q <= {le_q[LB-1], {LB{1'b0}}} - {{EW{1'b0}}, lf_q[LB-1]};
    gs_q <= ls_q[LB-1];
    mf_q <= mg[LB-1:0];
    mn_q <= mg[LB+EW-1:LB];
    ms_q <= ms_d;
  end

  // exp2 of the fraction: one constant root per bit
  logic [LB-1:0] xv_q;
  logic [MW-1:0] xg_q [LB];
  logic [LB-1:0] xf_q [LB];
  logic [EW-1:0] xn_q [LB];
  side_t         xs_q [LB];

  for (genvar k = 0; k < LB; k++) begin : g_exp
    localparam logic [MW-1:0] ROOT = gtc_pkg::exp_root(k + 1);
    logic          cv;
    logic [MW-1:0] cg;
    logic [LB-1:0] cf;
    logic [EW-1:0] cn;
    side_t         cs;
    logic [2*MW-1:0] prod;

    if (k == 0) begin : g_first
      assign cv = mv_q;
      assign cg = {1'b1, {MB{1'b0}}};
      assign cf = mf_q;
      assign cn = mn_q;
      assign cs = ms_q;
    end else begin : g_next
      assign cv = xv_q[k-1];
      assign cg = xg_q[k-1];
      assign cf = xf_q[k-1];
      assign cn = xn_q[k-1];
      assign cs = xs_q[k-1];
    end

    assign prod = cg * ROOT;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        xv_q[k] <= 1'b0;
      end else begin
        xv_q[k] <= cv;
      end
    end

    always_ff @(posedge clk_i) begin
      xg_q[k] <= cf[LB-1-k] ? prod[MW+MB-1:MB] : cg;
      xf_q[k] <= cf;
      xn_q[k] <= cn;
      xs_q[k] <= cs;
    end
  end

  // integer part as a right shift, then scale to full range
  logic          hv_q;
  logic [MW-1:0] hg_q;
  side_t         hs_q;
  logic [MW+7:0] sc;
  logic          valid_q;
  logic [VW-1:0] val_q;

  assign sc = {hg_q, 8'b0} - {8'b0, hg_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q    <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      hv_q    <= xv_q[LB-1];
      valid_q <= hv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hg_q  <= xg_q[LB-1] >> xn_q[LB-1];
    hs_q  <= xs_q[LB-1];
    val_q <= hs_q.fixed ? hs_q.val : VW'(sc[MB-FRAC_BITS +: DW]);
  end

  assign valid_o = valid_q;
  assign val_o   = val_q;

  `ASSERT_NEVER(a_gam_norm, clk_i, rst_ni, nv_q[NS-1] && !ns_q[NS-1].fixed && !nm_q[NS-1][MW-1])
  `ASSERT_CLK(a_gam_range, clk_i, rst_ni, valid_q && (cfg_i.inv_gamma != gtc_pkg::GAIN_ONE) |-> val_q <= FULL)

endmodule

@@ rtl/core/gtc_adjust.sv @@
// contrast around mid gray and brightness offset, both saturating
`include "assert_macros.svh"

module gtc_adjust #(
  parameter int FRAC_BITS = gtc_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  gtc_pkg::cfg_t                           cfg_i,
  input  logic                                    valid_i,
  input  logic [gtc_pkg::val_width(FRAC_BITS)-1:0] val_i,
  output logic                                    valid_o,
  output logic [15:0]                             gray_o
);

  localparam int VW = gtc_pkg::val_width(FRAC_BITS);
  localparam int PW = VW + 18;
  localparam int ZW = VW + 2;
  localparam logic [VW-1:0] FULL = VW'(255 << FRAC_BITS);
  localparam logic [VW-1:0] HALF = VW'(255 << (FRAC_BITS - 1));
  localparam logic [15:0] OUT_MAX = ((255 << FRAC_BITS) > 65535) ? 16'hFFFF
                                                                 : 16'(255 << FRAC_BITS);

  logic [3:0] valid_q;
  logic signed [VW:0]   s_q;
  logic signed [PW-1:0] prod_q;
  logic signed [PW-1:0] yc;
  logic [VW-1:0]        y_q;
  logic signed [ZW-1:0] z;
  logic [ZW-1:0]        zc;
  logic [15:0]          out_q;

  // arithmetic shift gives the floor also for negative products
  assign yc = (prod_q >>> 12) + $signed({{(PW-VW){1'b0}}, HALF});
  assign z  = $signed({2'b0, y_q}) + $signed({{(ZW-17){cfg_i.offset[16]}}, cfg_i.offset});

  always_comb begin
    if (z[ZW-1]) begin
      zc = '0;
    end else if (z > $signed({2'b0, FULL})) begin
      zc = {2'b0, FULL};
    end else begin
      zc = z;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    s_q    <= $signed({1'b0, val_i}) - $signed({1'b0, HALF});
    prod_q <= s_q * $signed({1'b0, cfg_i.gain});
    if (yc[PW-1]) begin
      y_q <= '0;
    end else if (yc > $signed({{(PW-VW){1'b0}}, FULL})) begin
      y_q <= FULL;
    end else begin
      y_q <= yc[VW-1:0];
    end
    out_q  <= (zc > ZW'(OUT_MAX)) ? OUT_MAX : zc[15:0];
  end

  assign valid_o = valid_q[3];
  assign gray_o  = out_q;

  `ASSERT_CLK(a_adj_range, clk_i, rst_ni, valid_q[3] |-> out_q <= OUT_MAX)

endmodule

@@ rtl/core/gray_tone_curve.sv @@
// gray tone curve top level: register file and the three pipeline sections
//
//   channel   direction  transfer when                 payload
//   command   in         start_i && !busy_o            gray_in_i
//   result    out        done_o (one cycle strobe)     gray_out_o
//   config    in         cfg_valid_i && cfg_ready_o    cfg_index_i, cfg_data_i
//
// one gray value can enter every cycle while busy_o is low: the levels divider takes FRAC_BITS + 8
// stages, and the gamma scaling, log2 squarings and exp2 products take 2 + 20 + 20 stages.
// busy_o and cfg_ready_o only stay low/high outside the cycle after reset release.
// results cannot be held off, so the pipeline never stalls.
module gray_tone_curve #(
  parameter int FRAC_BITS = gtc_pkg::FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [15:0] gray_in_i,
  output logic        done_o,
  output logic [15:0] gray_out_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i
);

  localparam int VW = gtc_pkg::val_width(FRAC_BITS);

  gtc_pkg::cfg_t cfg_q;
  logic          busy_q;
  logic          lv;
  logic [VW-1:0] lval;
  logic          gv;
  logic [VW-1:0] gval;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.black     <= 16'd0;
      cfg_q.white     <= 16'd65280;
      cfg_q.inv_gamma <= gtc_pkg::GAIN_ONE;
      cfg_q.gain      <= gtc_pkg::GAIN_ONE;
      cfg_q.offset    <= 17'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (gtc_pkg::reg_idx_e'(cfg_index_i))
        gtc_pkg::REG_BLACK:     cfg_q.black     <= cfg_data_i[15:0];
        gtc_pkg::REG_WHITE:     cfg_q.white     <= cfg_data_i[15:0];
        gtc_pkg::REG_INV_GAMMA: cfg_q.inv_gamma <= cfg_data_i[15:0];
        gtc_pkg::REG_GAIN:      cfg_q.gain      <= cfg_data_i[15:0];
        gtc_pkg::REG_OFFSET:    cfg_q.offset    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign busy_o      = busy_q;
  assign cfg_ready_o = !busy_q;

  gtc_levels #(.FRAC_BITS(FRAC_BITS)) u_levels (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (start_i && !busy_q),
    .gray_i  (gray_in_i),
    .valid_o (lv),
    .val_o   (lval)
  );

  gtc_gamma #(.FRAC_BITS(FRAC_BITS)) u_gamma (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (lv),
    .val_i   (lval),
    .valid_o (gv),
    .val_o   (gval)
  );

  gtc_adjust #(.FRAC_BITS(FRAC_BITS)) u_adjust (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (gv),
    .val_i   (gval),
    .valid_o (done_o),
    .gray_o  (gray_out_o)
  );

endmodule

@@ tb/gtc_checker.sv @@
// checker of the gray tone curve: watches the channels, predicts each result and compares
module gtc_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [15:0] gray_in_i,
  input  logic        done_i,
  input  logic [15:0] gray_out_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i,
  output int          pending_o,
  output int          fail_count_o,
  output int          checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint FULL = 255 << 8;
  localparam longint HALF = FULL / 2;

  logic [15:0] black_q, white_q, inv_gamma_q, gain_q;
  logic [16:0] offset_q;
  logic [15:0] tone_q[$];

  function automatic logic [63:0] floor_root(logic [63:0] a);
    logic [63:0] acc;
    logic [63:0] bitv;
    acc  = '0;
    bitv = 64'd1 << 62;
    while (bitv != 0) begin
      if (a >= acc + bitv) begin
        a   = a - (acc + bitv);
        acc = (acc >> 1) + bitv;
      end else begin
        acc = acc >> 1;
      end
      bitv = bitv >> 2;
    end
    return acc;
  endfunction

  function automatic longint gamma_curve(longint v);
    logic [63:0] t, m, frac, e, lg, mg, n, f, g, root;
    frac = 0;
    e    = 0;
    if (inv_gamma_q == gtc_pkg::GAIN_ONE) return v;
    if (inv_gamma_q == 0) return FULL;
    if (v <= 0) return 0;
    if (v >= FULL) return FULL;
    t = (64'(v) << gtc_pkg::MANT_BITS) / 64'(FULL);
    if (t == 0) return 0;
    m = t;
    while (m < (64'd1 << gtc_pkg::MANT_BITS)) begin
      m = m << 1;
      e = e + 1;
    end
    // log2 fraction by repeated squaring
    for (int i = 0; i < gtc_pkg::LOG_BITS; i++) begin
      m    = (m * m) >> gtc_pkg::MANT_BITS;
      frac = frac << 1;
      if (m >= (64'd2 << gtc_pkg::MANT_BITS)) begin
        m    = m >> 1;
        frac = frac | 1;
      end
    end
    lg = (e << gtc_pkg::LOG_BITS) - frac;
    mg = (lg * 64'(inv_gamma_q)) >> 12;
    n  = mg >> gtc_pkg::LOG_BITS;
    f  = mg & ((64'd1 << gtc_pkg::LOG_BITS) - 1);
    if (n >= 31) return 0;
    g    = 64'd1 << gtc_pkg::MANT_BITS;
    root = floor_root(64'd1 << 59);
    for (int i = 1; i <= gtc_pkg::LOG_BITS; i++) begin
      if (f[gtc_pkg::LOG_BITS - i]) g = (g * root) >> gtc_pkg::MANT_BITS;
      root = floor_root(root << gtc_pkg::MANT_BITS);
    end
    g = g >> n;
    return longint'((g * 64'(FULL)) >> gtc_pkg::MANT_BITS);
  endfunction

  function automatic longint clamp_gray(longint v);
    if (v < 0) return 0;
    if (v > FULL) return FULL;
    return v;
  endfunction

  function automatic logic [15:0] tone_map(logic [15:0] gray);
    longint v, b, w, prod, q, ofs;
    v   = longint'(gray);
    b   = longint'(black_q);
    w   = longint'(white_q);
    ofs = longint'(offset_q);
    if (offset_q[16]) ofs = ofs - 64'h20000;
    // levels
    if (w > b) begin
      if (v <= b) v = 0;
      else if (v >= w) v = FULL;
      else v = ((v - b) * FULL) / (w - b);
    end
    v = gamma_curve(v);
    // contrast around mid gray, floor division for negative products
    prod = (v - HALF) * longint'(gain_q);
    if (prod >= 0) q = prod / 4096;
    else q = -((-prod + 4095) / 4096);
    v = clamp_gray(q + HALF);
    v = clamp_gray(v + ofs);
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      black_q      = '0;
      white_q      = 16'd65280;
      inv_gamma_q  = gtc_pkg::GAIN_ONE;
      gain_q       = gtc_pkg::GAIN_ONE;
      offset_q     = '0;
      fail_count_o = 0;
      checked_o    = 0;
      tone_q.delete();
    end else begin
      if (done_i) begin
        if (tone_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected result gray_out=%0d", $time, gray_out_i);
        end else begin
          if (tone_q[0] !== gray_out_i) begin
            fail_count_o++;
            $display("%0t: gray_out expected %0d actual %0d", $time, tone_q[0],
                     gray_out_i);
          end
          void'(tone_q.pop_front());
          checked_o++;
        end
      end
      if (start_i && !busy_i) tone_q.push_back(tone_map(gray_in_i));
      // the bench must make config writes only while the pipeline is empty; the checker does not enforce it
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          gtc_pkg::REG_BLACK:     black_q     = cfg_data_i[15:0];
          gtc_pkg::REG_WHITE:     white_q     = cfg_data_i[15:0];
          gtc_pkg::REG_INV_GAMMA: inv_gamma_q = cfg_data_i[15:0];
          gtc_pkg::REG_GAIN:      gain_q      = cfg_data_i[15:0];
          gtc_pkg::REG_OFFSET:    offset_q    = cfg_data_i;
          default: ;
        endcase
      end
    end
    pending_o = tone_q.size();
  end

endmodule

@@ tb/tb_top.sv @@
// top of the gray tone curve testbench: clock, reset, stimulus and verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FULL = 65280;
  localparam int LIMIT = 600000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [15:0] gray_in_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [16:0] cfg_data_i = '0;
  logic        busy_o, done_o, cfg_ready_o;
  logic [15:0] gray_out_o;
  int          pending, fail_count, checked, cycles, sent, cfg_writes;
  bit          no_gaps;

  gray_tone_curve dut (.*);

  gtc_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .gray_in_i,
    .done_i(done_o), .gray_out_i(gray_out_o), .cfg_valid_i,
    .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .pending_o(pending), .fail_count_o(fail_count), .checked_o(checked)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic send_gray(logic [15:0] g);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    repeat (gap) begin
      @(negedge clk_i);
      start_i = 1'b0;
    end
    @(negedge clk_i);
    start_i   = 1'b1;
    gray_in_i = g;
    do @(posedge clk_i); while (busy_o);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    start_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(gtc_pkg::reg_idx_e idx, logic [16:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    cfg_writes++;
  endtask

  task automatic set_curve(logic [15:0] b, logic [15:0] w, logic [15:0] ig,
                           logic [15:0] gain, int ofs);
    drain();
    write_reg(gtc_pkg::REG_BLACK, {1'b0, b});
    write_reg(gtc_pkg::REG_WHITE, {1'b0, w});
    write_reg(gtc_pkg::REG_INV_GAMMA, {1'b0, ig});
    write_reg(gtc_pkg::REG_GAIN, {1'b0, gain});
    write_reg(gtc_pkg::REG_OFFSET, ofs[16:0]);
  endtask

  function automatic logic [15:0] rand_gray();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return 16'($urandom_range(FULL + 1, 65535));
    if (sel == 1) return (sel[0]) ? 16'(FULL) : 16'd0;
    return 16'($urandom_range(0, FULL));
  endfunction

  function automatic logic [15:0] rand_gain();
    case ($urandom_range(0, 5))
      0: return gtc_pkg::GAIN_ONE;
      1: return 16'd0;
      2: return 16'hffff;
      default: return 16'($urandom_range(2048, 8192));
    endcase
  endfunction

  initial begin
    logic [15:0] b, w, ig;
    int          ofs;
    logic [15:0] corner_vals [7];
    sent = 0;
    cfg_writes = 0;
    no_gaps = 1'b0;
    corner_vals = '{16'd0, 16'd1, 16'd32640, 16'h7fff, 16'h8000, 16'd65280, 16'd65535};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset setting, extremes and raw values above full scale
    foreach (corner_vals[i])
      send_gray(corner_vals[i]);
    // levels bypassed, strong gamma, unknown register index ignored
    set_curve(16'd65280, 16'd0, 16'd1, 16'hffff, -65280);
    write_reg(gtc_pkg::reg_idx_e'(3'd5), 17'h1ffff);
    send_gray(16'd0); send_gray(16'd65535); send_gray(16'd40000);
    // zero exponent, also for a zero input
    set_curve(16'd1000, 16'd60000, 16'd0, 16'd0, 65280);
    send_gray(16'd0); send_gray(16'd999); send_gray(16'd60000);
    set_curve(16'd1000, 16'd60000, 16'hffff, 16'd8192, 0);
    send_gray(16'd1000); send_gray(16'd1001); send_gray(16'd30000);
    send_gray(16'd59999); send_gray(16'd65535);
    set_curve(16'd0, 16'd65280, 16'd2048, 16'd4096, -100);
    send_gray(16'd1); send_gray(16'd300); send_gray(16'd65280);
    send_gray(16'd65535);

    // random: each phase draws a fresh curve, some phases run without gaps
    for (int ph = 0; ph < 12; ph++) begin
      b = 16'($urandom_range(0, 20000));
      w = ($urandom_range(0, 7) == 0) ? b : 16'($urandom_range(40000, FULL));
      case ($urandom_range(0, 4))
        0: ig = gtc_pkg::GAIN_ONE;
        1: ig = 16'($urandom_range(1, 65535));
        default: ig = 16'($urandom_range(1500, 12000));
      endcase
      ofs = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 130560) - 65280
                                        : $urandom_range(0, 8000) - 4000;
      set_curve(b, w, ig, rand_gain(), ofs);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 100; k++) begin
        send_gray(rand_gray());
        // in phase 3, after value 50, the sender holds off until the pipeline has emptied
        if (k == 50 && ph == 3) drain();
      end
    end

    drain();
    repeat (120) @(negedge clk_i);
    $display("sent %0d gray values, checked %0d results over %0d register writes",
             sent, checked, cfg_writes);
    $display("covered levels and gamma bypass, zero exponent, gain and offset extremes");
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/gtc_pkg.sv
rtl/core/gtc_div.sv
rtl/core/gtc_levels.sv
rtl/core/gtc_gamma.sv
rtl/core/gtc_adjust.sv
rtl/core/gray_tone_curve.sv
tb/gtc_checker.sv
tb/tb_top.sv
